>>> design/dcq_pkg.sv
// shared types and codes of the dual circular queue
package dcq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct packed {
    logic latch_req;
    logic exec;
    logic load_out;
  } dcq_cmd_t;

endpackage

>>> design/dcq_datapath.sv
// request registers, queue pointers, shared storage and result register
module dcq_datapath #(
  parameter int unsigned ArrayDepth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dcq_pkg::dcq_cmd_t             cmd_i,
  input  logic                          req_type_i,
  input  logic                          queue_sel_i,
  input  logic signed [dcq_pkg::DataW-1:0] value_i,
  output logic signed [dcq_pkg::DataW-1:0] data_out_o,
  output logic [1:0]                    status_o
);
  import dcq_pkg::*;

  localparam int unsigned PtrW   = $clog2(ArrayDepth);
  localparam int unsigned Q1Base = ArrayDepth / 2 + 1;
  localparam logic [PtrW-1:0] Base0 = '0;
  localparam logic [PtrW-1:0] Last0 = PtrW'(Q1Base - 1);
  localparam logic [PtrW-1:0] Base1 = PtrW'(Q1Base);
  localparam logic [PtrW-1:0] Last1 = PtrW'(ArrayDepth - 1);

  logic [DataW-1:0] mem [ArrayDepth];

  logic             req_type_q;
  logic             q_sel_q;
  logic [DataW-1:0] value_q;
  logic [PtrW-1:0]  front_q [2];
  logic [PtrW-1:0]  rear_q  [2];
  status_e          status_q;
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] out_data_q;
  status_e          out_status_q;

  logic [PtrW-1:0] cur_front, cur_rear, base, last, nxt_front, nxt_rear;
  logic            full, empty;

  always_comb begin
    cur_front = front_q[q_sel_q];
    cur_rear  = rear_q[q_sel_q];
    base      = q_sel_q ? Base1 : Base0;
    last      = q_sel_q ? Last1 : Last0;
    nxt_front = (cur_front == last) ? base : cur_front + PtrW'(1);
    nxt_rear  = (cur_rear == last) ? base : cur_rear + PtrW'(1);
    full      = (nxt_rear == cur_front);
    empty     = (cur_front == cur_rear);
  end

  // request capture, status check and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q <= req_type_i;
      q_sel_q    <= queue_sel_i;
      value_q    <= value_i;
    end
    if (cmd_i.exec) begin
      if (req_type_q == OP_INSERT) begin
        status_q <= full ? ST_FULL : ST_INSERTED;
      end else begin
        status_q <= empty ? ST_EMPTY : ST_REMOVED;
      end
    end
    if (cmd_i.load_out) begin
      out_data_q   <= (status_q == ST_REMOVED) ? rdata_q : '0;
      out_status_q <= status_q;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q[0] <= Base0;
      rear_q[0]  <= Base0;
      front_q[1] <= Base1;
      rear_q[1]  <= Base1;
    end else if (cmd_i.exec) begin
      if (req_type_q == OP_INSERT) begin
        if (!full) rear_q[q_sel_q] <= nxt_rear;
      end else begin
        if (!empty) front_q[q_sel_q] <= nxt_front;
      end
    end
  end

  // shared storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && req_type_q == OP_INSERT && !full) begin
      mem[nxt_rear] <= value_q;
    end
    if (cmd_i.exec && req_type_q == OP_DELETE && !empty) begin
      rdata_q <= mem[nxt_front];
    end
  end

  assign data_out_o = out_data_q;
  assign status_o   = out_status_q;

endmodule

>>> design/dcq_ctrl.sv
// sequencing state machine and result handshake
module dcq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dcq_pkg::dcq_cmd_t cmd_o
);
  import dcq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  always_comb begin
    slot_free       = !out_valid_q || !out_stall_i;
    cmd_o.latch_req = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.load_out  = (state_q == S_LOAD) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/dual_circular_queue_unit.sv
// top level of the dual circular queue
// Two circular queues share one array of ARRAY_DEPTH words: queue 0 holds
// slots 0 to ARRAY_DEPTH/2, queue 1 the slots above. Each queue holds one
// word fewer than its region.
// Input channel: in_valid_i / in_stall_o with req_type_i (0 insert,
// 1 delete), queue_sel_i and value_i. A beat is taken when valid is high
// and stall is low.
// Output channel: out_valid_o / out_stall_i with data_out_o and status_o
// (0 inserted, 1 removed, 2 full, 3 empty); one result beat per request.
// Sequence: the request beat is captured in the request registers; in the
// exec state the pointer check and storage access set the status and read
// data; in the load state both go into the result register once it is free.
// The sequencer handles one request at a time through the single storage
// port and stalls the input until that request's result is loaded.
// A new request is taken while an earlier result still waits in the output
// register; if the receiver stalls, the next result waits in the sequencer
// and the input stalls until the output register frees.
// Reset puts both queues empty at their region bases; storage is not
// cleared and needs no clearing pass.
module dual_circular_queue_unit #(
  parameter int unsigned ARRAY_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic                             queue_sel_i,
  input  logic signed [dcq_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [dcq_pkg::DataW-1:0] data_out_o,
  output logic [1:0]                       status_o
);
  import dcq_pkg::*;

  dcq_cmd_t cmd;

  dcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dcq_datapath #(
    .ArrayDepth (ARRAY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (req_type_i),
    .queue_sel_i (queue_sel_i),
    .value_i     (value_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.latch_req, cmd.exec, cmd.load_out}))
    else $error("more than one command at once");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat taken while a request is in flight");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_REMOVED) |-> (data_out_o == '0))
    else $error("non-zero data on a result without removal");

endmodule
